### rtl/second_chance_page_replacer_core_assert.svh
// Assertion macros for the second-chance page replacer checker.
// No dependencies; included by the checker file.
`ifndef SECOND_CHANCE_PAGE_REPLACER_CORE_ASSERT_SVH
`define SECOND_CHANCE_PAGE_REPLACER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SCPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scpr_pkg.sv
// Shared constants for the second-chance page replacer.
// No dependencies; used by the core and its checker.
package scpr_pkg;

    // build defaults
    localparam int FRAME_CAPACITY_DEF = 16;
    localparam int PAGE_BITS_DEF      = 20;

    // configuration register
    localparam int ACTIVE_W          = 5;
    localparam int ACTIVE_FRAMES_RST = 16;
    localparam int REG_ACTIVE_FRAMES = 0;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    // result word layout
    localparam int FRAME_W    = 4;
    localparam int COUNT_W    = 32;
    localparam int HIT_LSB    = 0;
    localparam int FRAME_LSB  = HIT_LSB + 1;
    localparam int REQ_LSB    = FRAME_LSB + FRAME_W;
    localparam int FAULT_LSB  = REQ_LSB + COUNT_W;
    localparam int RES_BITS   = FAULT_LSB + COUNT_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

endpackage

### rtl/second_chance_page_replacer_core.sv
// Second-chance (clock) page replacement core.
// Depends on scpr_pkg and scpr_ram.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata: page_number
//  m_*       out  m_tvalid / m_tready    m_tdata: hit, frame, request_count, fault_count
//  apb       in   psel & penable         register 0: active_frames
//
// One word at a time. With n active frames, a lookup reads the page RAM one
// frame per cycle up to the first match or frame n-1; a miss then sweeps the
// hand one frame per cycle until it replaces a frame with a clear reference bit.
// ST_FIN loads the result register once the output is free; a new word is then
// taken even while the result waits on m_tready. Reset is synchronous, active
// low, clears valid and reference bits at once; the page RAM needs no clearing.
module second_chance_page_replacer_core #(
    parameter int FRAME_CAPACITY = scpr_pkg::FRAME_CAPACITY_DEF,
    parameter int PAGE_BITS      = scpr_pkg::PAGE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words: [PAGE_BITS-1:0] page_number, zero fill to bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]      s_tdata,
    // result words: [0] hit, [4:1] frame, [36:5] request_count, [68:37] fault_count
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scpr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scpr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [scpr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [scpr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W  = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
    localparam int SIZE_W = $clog2(FRAME_CAPACITY + 1);
    localparam int CNT_W  = scpr_pkg::COUNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [scpr_pkg::ACTIVE_W-1:0] active_reg, active_next;
    logic [PAGE_BITS-1:0]        page_reg, page_next;
    logic [SIZE_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                        cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [SIZE_W-1:0]           hand_reg, hand_next;
    logic [FRAME_CAPACITY-1:0]   valid_reg, valid_next;
    logic [FRAME_CAPACITY-1:0]   refb_reg, refb_next;
    logic [CNT_W-1:0]            req_reg, req_next;
    logic [CNT_W-1:0]            fault_reg, fault_next;
    logic                        res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]            res_slot_reg, res_slot_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [scpr_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SIZE_W-1:0]           eff_size;
    logic [SIZE_W-1:0]           hand_inc;
    logic [SIZE_W-1:0]           hand_wrap;
    logic [IDX_W-1:0]            hand_idx;
    logic                        ram_we;
    logic [PAGE_BITS-1:0]        ram_rdata;
    logic                        match;
    logic                        s_fire;
    logic                        out_free;
    logic                        cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        active_next = active_reg;
        if (cfg_wr && (paddr[scpr_pkg::APB_ADDR_W-1:2] ==
                       (scpr_pkg::APB_ADDR_W-2)'(scpr_pkg::REG_ACTIVE_FRAMES))) begin
            active_next = pwdata[scpr_pkg::ACTIVE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[scpr_pkg::APB_ADDR_W-1:2] ==
            (scpr_pkg::APB_ADDR_W-2)'(scpr_pkg::REG_ACTIVE_FRAMES)) begin
            prdata = scpr_pkg::APB_DATA_W'(active_reg);
        end
    end

    // clamp the active size to 1..FRAME_CAPACITY
    always_comb begin
        if (active_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(active_reg) > FRAME_CAPACITY) begin
            eff_size = SIZE_W'(FRAME_CAPACITY);
        end else begin
            eff_size = SIZE_W'(active_reg);
        end
    end

    // hand step with wrap at the active size
    assign hand_idx  = hand_reg[IDX_W-1:0];
    assign hand_inc  = hand_reg + SIZE_W'(1);
    assign hand_wrap = (hand_inc >= eff_size) ? '0 : hand_inc;

    // page RAM: read one frame per scan cycle, write on replacement
    scpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAME_CAPACITY)
    ) u_page_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (hand_idx),
        .wdata (page_reg),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign match    = cmp_pend_reg && valid_reg[cmp_idx_reg] && (ram_rdata == page_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer: scan, sweep, deliver
    always_comb begin
        state_next    = state_reg;
        page_next     = page_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_pend_next = cmp_pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        hand_next     = hand_reg;
        valid_next    = valid_reg;
        refb_next     = refb_reg;
        req_next      = req_reg;
        fault_next    = fault_reg;
        res_hit_next  = res_hit_reg;
        res_slot_next = res_slot_reg;
        ram_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    page_next     = s_tdata[PAGE_BITS-1:0];
                    rd_idx_next   = '0;
                    cmp_pend_next = 1'b0;
                    if (req_reg != CNT_MAX) begin
                        req_next = req_reg + CNT_W'(1);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    // hit: lowest matching frame gets its second chance
                    refb_next[cmp_idx_reg] = 1'b1;
                    res_hit_next  = 1'b1;
                    res_slot_next = cmp_idx_reg;
                    state_next    = ST_FIN;
                end else if (!cmp_pend_reg && (rd_idx_reg >= eff_size)) begin
                    // miss: restart a stale hand at frame 0
                    if (hand_reg >= eff_size) begin
                        hand_next = '0;
                    end
                    state_next = ST_SWEEP;
                end else if (rd_idx_reg < eff_size) begin
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + SIZE_W'(1);
                end else begin
                    cmp_pend_next = 1'b0;
                end
            end
            ST_SWEEP: begin
                if (refb_reg[hand_idx]) begin
                    // clear and skip
                    refb_next[hand_idx] = 1'b0;
                    hand_next = hand_wrap;
                end else begin
                    // replace this frame
                    ram_we                = 1'b1;
                    valid_next[hand_idx]  = 1'b1;
                    res_hit_next          = 1'b0;
                    res_slot_next         = hand_idx;
                    hand_next             = hand_wrap;
                    if (fault_reg != CNT_MAX) begin
                        fault_next = fault_reg + CNT_W'(1);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[scpr_pkg::HIT_LSB] = res_hit_reg;
                    m_tdata_next[scpr_pkg::FRAME_LSB +: scpr_pkg::FRAME_W] =
                        scpr_pkg::FRAME_W'(res_slot_reg);
                    m_tdata_next[scpr_pkg::REQ_LSB +: CNT_W]   = req_reg;
                    m_tdata_next[scpr_pkg::FAULT_LSB +: CNT_W] = fault_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= scpr_pkg::ACTIVE_W'(scpr_pkg::ACTIVE_FRAMES_RST);
            cmp_pend_reg <= 1'b0;
            hand_reg     <= '0;
            valid_reg    <= '0;
            refb_reg     <= '0;
            req_reg      <= '0;
            fault_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            cmp_pend_reg <= cmp_pend_next;
            hand_reg     <= hand_next;
            valid_reg    <= valid_next;
            refb_reg     <= refb_next;
            req_reg      <= req_next;
            fault_reg    <= fault_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/scpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the page number of each frame.
module scpr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/scpr_checker.sv
// Port-level checker for the second-chance page replacer, with its bind.
// Depends on scpr_pkg and second_chance_page_replacer_core_assert.svh.
`include "second_chance_page_replacer_core_assert.svh"

module scpr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [scpr_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [scpr_pkg::COUNT_W-1:0] req_cnt;
    logic [scpr_pkg::COUNT_W-1:0] fault_cnt;

    assign req_cnt   = m_tdata[scpr_pkg::REQ_LSB +: scpr_pkg::COUNT_W];
    assign fault_cnt = m_tdata[scpr_pkg::FAULT_LSB +: scpr_pkg::COUNT_W];

    // a stalled result word holds
    `SCPR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one word in flight: the input closes right after an accept
    `SCPR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "input taken while a word is in work")

    // every result counts at least its own request
    `SCPR_ASSERT_NOW(a_req_nonzero, aclk, aresetn, m_tvalid,
        req_cnt != '0, "request count is zero in a result")

    // faults never outrun requests
    `SCPR_ASSERT_NOW(a_fault_le_req, aclk, aresetn, m_tvalid,
        fault_cnt <= req_cnt, "fault count above request count")

endmodule

bind second_chance_page_replacer_core scpr_checker u_scpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/page_replacer_checker.sv
// Scoreboard for the second-chance page replacer: follows the APB writes,
// predicts each lookup from its own copy of the frame table, and compares.
// Depends on scpr_pkg for widths, the register index and the result layout.
module page_replacer_checker
    import scpr_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int PAGE_BITS      = PAGE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // [PAGE_BITS-1:0] page_number, zero fill to bytes
    input  logic [((PAGE_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] hit, [4:1] frame, [36:5] request_count, [68:37] fault_count
    input  logic [OUT_DATA_W-1:0]            m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [APB_ADDR_W-1:0]            paddr,
    input  logic [APB_DATA_W-1:0]            pwdata,
    input  logic [APB_DATA_W-1:0]            prdata,
    input  logic                             pready,
    output int                               mismatches,
    output int                               pending,
    output int                               refs_checked,
    output int                               hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] ACTIVE_ADDR = APB_ADDR_W'(4 * REG_ACTIVE_FRAMES);

    // packed so that the last field, hit, sits in the lowest bits of the word
    typedef struct packed {
        logic [COUNT_W-1:0] fault_count;
        logic [COUNT_W-1:0] request_count;
        logic [FRAME_W-1:0] frame;
        logic               hit;
    } lookup_result_t;

    // shadow of the frame table and counters
    logic [PAGE_BITS-1:0] page_of [FRAME_CAPACITY];
    bit                   in_use [FRAME_CAPACITY];
    bit                   second_chance [FRAME_CAPACITY];
    int unsigned          hand;
    logic [COUNT_W-1:0]   req_total;
    logic [COUNT_W-1:0]   fault_total;
    logic [ACTIVE_W-1:0]  active_reg;
    lookup_result_t       awaited_results [$];

    task automatic flag_mismatch(input string what);
        $display("[%0t] page replacer: %s", $realtime, what);
        mismatches++;
    endtask

    // Look the page up, run the clock sweep on a miss, and return the outcome
    function automatic lookup_result_t resolve_reference(input logic [PAGE_BITS-1:0] page);
        int unsigned    span;
        int unsigned    slot;
        int unsigned    h;
        bit             found;
        lookup_result_t r;
        span  = (active_reg == 0) ? 1 :
                ((active_reg > FRAME_CAPACITY) ? FRAME_CAPACITY : active_reg);
        found = 1'b0;
        slot  = 0;
        if (req_total != '1) req_total++;
        // lowest matching frame wins when duplicates exist
        for (int i = 0; i < span; i++) begin
            if (!found && in_use[i] && page_of[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            second_chance[slot] = 1'b1;
        end else begin
            // a hand left beyond the active size restarts at frame 0
            h = (hand >= span) ? 0 : hand;
            for (int k = 0; k < 2 * span && second_chance[h]; k++) begin
                second_chance[h] = 1'b0;
                h = (h + 1 >= span) ? 0 : h + 1;
            end
            slot                = h;
            page_of[slot]       = page;
            in_use[slot]        = 1'b1;
            second_chance[slot] = 1'b0;
            hand                = (h + 1 >= span) ? 0 : h + 1;
            if (fault_total != '1) fault_total++;
        end
        r.hit           = found;
        r.frame         = FRAME_W'(slot);
        r.request_count = req_total;
        r.fault_count   = fault_total;
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < FRAME_CAPACITY; i++) begin
                page_of[i]       = '0;
                in_use[i]        = 1'b0;
                second_chance[i] = 1'b0;
            end
            hand         = 0;
            req_total    = '0;
            fault_total  = '0;
            active_reg   = ACTIVE_W'(ACTIVE_FRAMES_RST);
            awaited_results.delete();
            mismatches   = 0;
            refs_checked = 0;
            hits_seen    = 0;
        end else begin
            // track register writes, verify read-back
            if (psel && penable && pready && paddr == ACTIVE_ADDR) begin
                if (pwrite) begin
                    active_reg = pwdata[ACTIVE_W-1:0];
                end else if (prdata !== APB_DATA_W'(active_reg)) begin
                    flag_mismatch($sformatf("active_frames read 0x%0h, want 0x%0h",
                                            prdata, active_reg));
                end
            end
            // compare a delivered word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = lookup_result_t'(m_tdata[RES_BITS-1:0]);
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word 0x%0h", m_tdata));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.hit !== want.hit)
                        flag_mismatch($sformatf("ref %0d: hit %0b, want %0b",
                                                refs_checked, got.hit, want.hit));
                    if (got.frame !== want.frame)
                        flag_mismatch($sformatf("ref %0d: frame %0d, want %0d",
                                                refs_checked, got.frame, want.frame));
                    if (got.request_count !== want.request_count)
                        flag_mismatch($sformatf("ref %0d: request_count %0d, want %0d",
                                                refs_checked, got.request_count,
                                                want.request_count));
                    if (got.fault_count !== want.fault_count)
                        flag_mismatch($sformatf("ref %0d: fault_count %0d, want %0d",
                                                refs_checked, got.fault_count,
                                                want.fault_count));
                    if (want.hit) hits_seen++;
                    refs_checked++;
                end
            end
            // predict each accepted reference
            if (s_tvalid && s_tready)
                awaited_results.push_back(resolve_reference(s_tdata[PAGE_BITS-1:0]));
        end
        pending = awaited_results.size();
    end

endmodule

### tb/second_chance_page_replacer_core_tb.sv
// Top of the page replacer testbench: clock, reset, page stream, result sink
// and APB register traffic. Depends on scpr_pkg, the core and page_replacer_checker.
module second_chance_page_replacer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scpr_pkg::*;

    localparam int PAGE_BITS        = PAGE_BITS_DEF;
    localparam int S_W              = ((PAGE_BITS + 7) / 8) * 8;
    localparam int TAIL_CYCLES      = 4 * FRAME_CAPACITY_DEF + 16;
    localparam int LONG_HOLD        = 350;
    localparam int PHASE_REFS       = 100;
    localparam int POOL_DEPTH       = 24;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam logic [APB_ADDR_W-1:0] ACTIVE_ADDR = APB_ADDR_W'(4 * REG_ACTIVE_FRAMES);

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_W-1:0]          s_tdata  = '0;   // [19:0] page_number
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;         // [0] hit, [4:1] frame, [36:5] req, [68:37] fault
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int mismatches;
    int pending;
    int refs_checked;
    int hits_seen;

    int unsigned          send_calm = 0;
    int unsigned          settings_used = 0;
    logic [PAGE_BITS-1:0] hot_pages [POOL_DEPTH];

    second_chance_page_replacer_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    page_replacer_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .mismatches(mismatches), .pending(pending),
        .refs_checked(refs_checked), .hits_seen(hits_seen)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Random wait per word, with occasional stretches of back-to-back words
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 60);
        return $urandom_range(0, 18);
    endfunction

    // Offer one page reference and hold it until accepted
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int unsigned gap;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(page);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, drain every outstanding result, then let the core go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write active_frames, then read it back for the checker
    task automatic set_active_frames(input logic [ACTIVE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACTIVE_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // Result sink: random stalls, plus a long hold now and then to back up the core
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        int unsigned calm;
        taken = 0;
        calm  = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(calm);
            if (taken % 400 == 150) stall = LONG_HOLD;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : page_stream
        logic [PAGE_BITS-1:0] opening_refs [9];
        logic [PAGE_BITS-1:0] narrow_refs [5];
        logic [PAGE_BITS-1:0] widen_refs [3];
        logic [ACTIVE_W-1:0]  frame_settings [12];
        int unsigned          span;
        int unsigned          pool_span;
        opening_refs = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h05555,
                         20'hAAAAA, 20'h05555, 20'h00007, 20'h00008};
        narrow_refs  = '{20'h05555, 20'h00000, 20'hFFFFF, 20'h12345, 20'hAAAAA};
        widen_refs   = '{20'hAAAAA, 20'h00007, 20'h00008};
        frame_settings = '{5'd5, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2,
                           5'd12, 5'd16, 5'd7, 5'd3, 5'd9, 5'd16};
        for (int i = 0; i < POOL_DEPTH; i++) hot_pages[i] = PAGE_BITS'($urandom);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill empty frames at the reset size, with hits setting reference bits
        foreach (opening_refs[i]) send_page(opening_refs[i]);
        // shrink below the hand: hits everywhere, then a full clearing pass
        settle();
        set_active_frames(5'd3);
        foreach (narrow_refs[i]) send_page(narrow_refs[i]);
        // grow again: duplicate page in two frames, hidden frames come back
        settle();
        set_active_frames(5'd16);
        foreach (widen_refs[i]) send_page(widen_refs[i]);

        // random phases: mostly a hot set a bit larger than the active size
        foreach (frame_settings[p]) begin
            settle();
            set_active_frames(frame_settings[p]);
            span = (frame_settings[p] == 0) ? 1 :
                   ((frame_settings[p] > FRAME_CAPACITY_DEF) ? FRAME_CAPACITY_DEF
                                                             : frame_settings[p]);
            pool_span = span + $urandom_range(1, 6);
            if (pool_span > POOL_DEPTH) pool_span = POOL_DEPTH;
            // keep half the hot set so stale copies meet the new size
            for (int i = 0; i < POOL_DEPTH; i++)
                if ($urandom_range(0, 1) == 0) hot_pages[i] = PAGE_BITS'($urandom);
            repeat (PHASE_REFS) begin
                if ($urandom_range(0, 99) < 85)
                    send_page(hot_pages[$urandom_range(0, pool_span - 1)]);
                else
                    send_page(PAGE_BITS'($urandom));
            end
        end
        settle();

        $display("Checked %0d page references: %0d hits, %0d faults.",
                 refs_checked, hits_seen, refs_checked - hits_seen);
        $display("Ran %0d active-frame settings from 0 through 31, with receiver backups.",
                 settings_used);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8 * RUN_LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scpr_pkg.sv
rtl/scpr_ram.sv
rtl/second_chance_page_replacer_core.sv
rtl/scpr_checker.sv
tb/page_replacer_checker.sv
tb/second_chance_page_replacer_core_tb.sv
